/* hdl/alist_pkg.sv */
// Shared constants for the array list engine: operation and status codes, field widths.
package alist_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int OP_W     = 2;
  localparam int POS_W    = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = 5;
  localparam int CNT_W    = 5;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic [IDX_W-1:0] FOUND_NONE = 5'h1F;

endpackage

/* hdl/array_list_engine_core.sv */
// Array list engine: ordered list of signed words held in one synchronous memory.
// Refusals, the unused op and a delete of the last entry go to the result directly, an insert at
// the tail writes the value first; other inserts shift entries up, deletes shift down and a
// find compares from index 0 to a match or the end. One entry is moved or compared per cycle
// (read one address, write another); a new beat is taken in the cycle after the result is
// registered. rst_n is synchronous, active low, empties the list, keeps memory.
module array_list_engine_core #(
  parameter int CAPACITY = alist_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: position [7:0], value [39:8]
  input  logic [alist_pkg::IN_DATA_W-1:0]   in_tdata,
  // tuser: op [1:0]
  input  logic [alist_pkg::OP_W-1:0]        in_tuser,
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: status [1:0], found_index [6:2], entry_count [11:7], zero [15:12]
  output logic [alist_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // Address width indexes the memory; the count width must also hold CAPACITY itself.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  // Wide enough to compare an 8-bit position with count+1 without overflow.
  localparam int XW = ((CW > alist_pkg::POS_W) ? CW : alist_pkg::POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_SCAN,
    S_DONE
  } state_t;

  // Entry store and its registered read port.
  logic [alist_pkg::VALUE_W-1:0] mem [CAPACITY];
  logic [alist_pkg::VALUE_W-1:0] rd_q_r;

  logic                          mem_we;
  logic [AW-1:0]                 mem_wa;
  logic [alist_pkg::VALUE_W-1:0] mem_wd;
  logic                          mem_re;
  logic [AW-1:0]                 mem_ra;

  state_t                         state_r, state_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [AW-1:0]                  ptr_r, ptr_nxt;
  logic [AW-1:0]                  lo_r, lo_nxt;
  logic [alist_pkg::VALUE_W-1:0]  value_r, value_nxt;
  logic [alist_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [alist_pkg::IDX_W-1:0]    res_found_r, res_found_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [alist_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Unpacked input beat.
  logic [alist_pkg::OP_W-1:0]    in_op;
  logic [alist_pkg::POS_W-1:0]   in_pos;
  logic [alist_pkg::VALUE_W-1:0] in_value;

  logic           in_fire;
  logic           out_free;
  logic [XW-1:0]  pos_x;
  logic [XW-1:0]  cnt_x;
  logic [XW-1:0]  pos_m1_x;
  logic [AW-1:0]  pos_lo;
  logic [AW+alist_pkg::IDX_W-1:0] ptr_ext;
  logic [CW+alist_pkg::CNT_W-1:0] cnt_ext;

  assign in_op    = in_tuser;
  assign in_pos   = in_tdata[alist_pkg::POS_W-1:0];
  assign in_value = in_tdata[alist_pkg::POS_W +: alist_pkg::VALUE_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign pos_x    = XW'(in_pos);
  assign cnt_x    = XW'(count_r);
  assign pos_m1_x = pos_x - XW'(1);
  // Only used once the position has been checked, so it always fits the address.
  assign pos_lo   = pos_m1_x[AW-1:0];

  // Output fields carry the low five bits of the index and of the count.
  assign ptr_ext = {{alist_pkg::IDX_W{1'b0}}, ptr_r};
  assign cnt_ext = {{alist_pkg::CNT_W{1'b0}}, count_r};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    lo_nxt         = lo_r;
    value_nxt      = value_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_wa         = ptr_r;
    mem_wd         = rd_q_r;
    mem_re         = 1'b0;
    mem_ra         = ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_status_nxt = alist_pkg::ST_DONE;
          res_found_nxt  = alist_pkg::FOUND_NONE;
          value_nxt      = in_value;
          lo_nxt         = pos_lo;
          state_nxt      = S_DONE;
          unique case (in_op)
            alist_pkg::OP_INSERT: begin
              if (count_r >= CW'(CAPACITY)) begin
                res_status_nxt = alist_pkg::ST_FULL;
              end else if (in_pos == '0 || pos_x > cnt_x + XW'(1)) begin
                res_status_nxt = alist_pkg::ST_RANGE;
              end else if (pos_m1_x == cnt_x) begin
                // Append at the tail: nothing to move.
                state_nxt = S_PUT;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = AW'(count_r - CW'(1));
                ptr_nxt   = AW'(count_r);
                state_nxt = S_SHIFT_UP;
              end
            end
            alist_pkg::OP_DELETE: begin
              if (in_pos == '0 || pos_x > cnt_x) begin
                res_status_nxt = alist_pkg::ST_RANGE;
              end else if (pos_x == cnt_x) begin
                // Last entry: dropping it needs no move.
                count_nxt = count_r - CW'(1);
              end else begin
                mem_re    = 1'b1;
                mem_ra    = AW'(pos_lo + AW'(1));
                ptr_nxt   = pos_lo;
                state_nxt = S_SHIFT_DN;
              end
            end
            alist_pkg::OP_FIND: begin
              if (count_r != '0) begin
                mem_re    = 1'b1;
                mem_ra    = '0;
                ptr_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              // Unused op: report the current count and no index.
            end
          endcase
        end
      end

      S_SHIFT_UP: begin
        // Entry ptr-1 has arrived; it moves to ptr.
        mem_we = 1'b1;
        mem_wa = ptr_r;
        mem_wd = rd_q_r;
        if (ptr_r - AW'(1) == lo_r) begin
          state_nxt = S_PUT;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = ptr_r - AW'(2);
          ptr_nxt = ptr_r - AW'(1);
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_wa    = lo_r;
        mem_wd    = value_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end

      S_SHIFT_DN: begin
        // Entry ptr+1 has arrived; it moves to ptr.
        mem_we = 1'b1;
        mem_wa = ptr_r;
        mem_wd = rd_q_r;
        if (CW'(ptr_r) + CW'(2) == count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = ptr_r + AW'(2);
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      S_SCAN: begin
        if (rd_q_r == value_r) begin
          res_found_nxt = ptr_ext[alist_pkg::IDX_W-1:0];
          state_nxt     = S_DONE;
        end else if (CW'(ptr_r) + CW'(1) == count_r) begin
          state_nxt = S_DONE;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = ptr_r + AW'(1);
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0000, cnt_ext[alist_pkg::CNT_W-1:0], res_found_r, res_status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ptr_r        <= ptr_nxt;
    lo_r         <= lo_nxt;
    value_r      <= value_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule
